// ===== sv/fls_pkg.sv =====
// ============================================================================
// fls_pkg: shared types and constants for the lottery selector
// Widths, stream packing offsets, controller states and the command/status
// structs exchanged between controller and datapath.
// ============================================================================
package fls_pkg;

    // Default parameter values
    localparam int FLS_NUM_SOURCES = 8;
    localparam int FLS_RAND_BITS   = 16;

    // Field widths
    localparam int TICK_W  = 32;
    localparam int FLOOR_W = 16;
    localparam int CNT_W   = 48;
    localparam int RND_FW  = 16;
    localparam int MASK_W  = 8;
    localparam int SIDX_W  = 3;

    // Input stream packing, lowest bit first
    localparam int IDX_LSB   = 0;
    localparam int BASE_LSB  = IDX_LSB + SIDX_W;
    localparam int FOUND_LSB = BASE_LSB + FLOOR_W;
    localparam int EXEC_LSB  = FOUND_LSB + CNT_W;
    localparam int RND_LSB   = EXEC_LSB + CNT_W;
    localparam int MASK_LSB  = RND_LSB + RND_FW;
    localparam int S_FIELD_W = MASK_LSB + MASK_W;
    localparam int S_TDATA_W = ((S_FIELD_W + 7) / 8) * 8;

    // Output stream packing
    localparam int M_FIELD_W = SIDX_W + TICK_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    // Divider sizes
    localparam int DIV_NUM_W = 2 * TICK_W;
    localparam int DIV_DEN_W = TICK_W;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FLOOR_WR,
        ST_ADJ_CHK,
        ST_ADJ_MUL,
        ST_DIV_GO,
        ST_DIV_RUN,
        ST_ADJ_WR,
        ST_DRAW,
        ST_WALK,
        ST_ROTATE,
        ST_OUT
    } fls_state_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_WIN,
        RD_WALK,
        RD_PICK
    } rd_sel_t;

    typedef enum logic [1:0] {
        MUL_REWARD,
        MUL_PENALTY,
        MUL_DRAW
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     floor_wr;
        logic     streak_inc;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     adj_wr;
        logic     walk_clr;
        logic     walk_step;
        logic     rotate;
        logic     load_out;
    } fls_cmd_t;

    typedef struct packed {
        logic req_set;
        logic idx_ok;
        logic reward;
        logic penalty;
        logic t_zero;
        logic b_gt_t;
        logic div_busy;
        logic walk_done;
        logic out_free;
    } fls_status_t;

    // Add two 32-bit counts, saturating at all ones
    function automatic logic [TICK_W-1:0] sat_add32(input logic [TICK_W-1:0] a,
                                                    input logic [TICK_W-1:0] b);
        logic [TICK_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TICK_W] ? TICK_MAX : s[TICK_W-1:0];
    endfunction

    // Subtract, clamping at zero
    function automatic logic [TICK_W-1:0] clamp_sub32(input logic [TICK_W-1:0] a,
                                                      input logic [TICK_W-1:0] b);
        return (a >= b) ? (a - b) : '0;
    endfunction

endpackage

// ===== sv/fls_div.sv =====
// ============================================================================
// fls_div: radix-2 restoring divider
// Divides a 64-bit numerator by a 32-bit divisor, one quotient bit per cycle.
// The divisor must stay stable while busy is high.
// ============================================================================
module fls_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [fls_pkg::DIV_NUM_W-1:0] num,
    input  logic [fls_pkg::DIV_DEN_W-1:0] den,
    output logic                          busy,
    output logic [fls_pkg::DIV_NUM_W-1:0] quot,
    output logic                          rem_nz
);
    import fls_pkg::*;

    localparam int STEP_W = $clog2(DIV_NUM_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_NUM_W - 1);

    logic                  busy_reg, busy_next;
    logic [STEP_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0]  nq_reg, nq_next;
    logic [DIV_DEN_W-1:0]  rem_reg, rem_next;
    logic [DIV_DEN_W:0]    rem_sh;
    logic                  ge;

    // One shift-compare-subtract step
    always_comb begin
        rem_sh    = {rem_reg, nq_reg[DIV_NUM_W-1]};
        ge        = rem_sh >= {1'b0, den};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        nq_next   = nq_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            nq_next   = num;
            rem_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? DIV_DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DIV_DEN_W-1:0];
            nq_next  = {nq_reg[DIV_NUM_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        nq_reg  <= nq_next;
        rem_reg <= rem_next;
    end

    assign busy   = busy_reg;
    assign quot   = nq_reg;
    assign rem_nz = |rem_reg;

endmodule

// ===== sv/fls_ctrl.sv =====
// ============================================================================
// fls_ctrl: sequencing controller
// Walks one request at a time through decode, ticket adjustment, draw,
// running-sum walk, rotation and result hand-off.
// ============================================================================
module fls_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  fls_pkg::fls_status_t status,
    output fls_pkg::fls_cmd_t    cmd
);
    import fls_pkg::*;

    fls_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_WIN;
        cmd.mul_sel = MUL_DRAW;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = status.req_set ? RD_IDX : RD_WIN;
                if (status.req_set) begin
                    state_next = status.idx_ok ? ST_FLOOR_WR : ST_IDLE;
                end else begin
                    state_next = ST_ADJ_CHK;
                end
            end
            ST_FLOOR_WR: begin
                cmd.floor_wr = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_ADJ_CHK: begin
                if (status.reward) begin
                    state_next = (status.t_zero || status.b_gt_t) ? ST_ADJ_WR : ST_ADJ_MUL;
                end else if (status.penalty) begin
                    cmd.streak_inc = 1'b1;
                    state_next     = status.t_zero ? ST_ADJ_WR : ST_ADJ_MUL;
                end else begin
                    state_next = ST_DRAW;
                end
            end
            ST_ADJ_MUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = status.reward ? MUL_REWARD : MUL_PENALTY;
                state_next  = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (!status.div_busy) begin
                    state_next = ST_ADJ_WR;
                end
            end
            ST_ADJ_WR: begin
                cmd.adj_wr = 1'b1;
                state_next = ST_DRAW;
            end
            ST_DRAW: begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_DRAW;
                cmd.walk_clr = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_WALK;
                state_next   = ST_WALK;
            end
            ST_WALK: begin
                cmd.walk_step = 1'b1;
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = RD_WALK;
                if (status.walk_done) begin
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE: begin
                cmd.rotate = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PICK;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/fls_dp.sv =====
// ============================================================================
// fls_dp: selector datapath
// Ticket and floor stores, totals and counters, the shared multiplier,
// the divider, the running-sum walk, the rotation search and the result
// register.
// ============================================================================
module fls_dp #(
    parameter int NUM_SOURCES = fls_pkg::FLS_NUM_SOURCES,
    parameter int RAND_BITS   = fls_pkg::FLS_RAND_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [fls_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [fls_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    input  fls_pkg::fls_cmd_t             cmd,
    output fls_pkg::fls_status_t          status
);
    import fls_pkg::*;

    localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int SUM_W = TICK_W + IDX_W;
    localparam int RND_W = (RAND_BITS < RND_FW) ? RAND_BITS : RND_FW;
    localparam int PAD_W = M_TDATA_W - M_FIELD_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);

    // Captured request
    logic                req_reg;
    logic [SIDX_W-1:0]   idx_reg;
    logic [FLOOR_W-1:0]  base_reg;
    logic [CNT_W-1:0]    found_reg;
    logic [CNT_W-1:0]    exec_reg;
    logic [RND_W-1:0]    rnd_reg;
    logic [MASK_W-1:0]   mask_reg;

    // Stores with per-entry valid bits; an unwritten entry reads as one
    logic [TICK_W-1:0]      tick_mem  [NUM_SOURCES];
    logic [FLOOR_W-1:0]     floor_mem [NUM_SOURCES];
    logic [NUM_SOURCES-1:0] tick_vld_reg, tick_vld_next;
    logic [NUM_SOURCES-1:0] floor_vld_reg, floor_vld_next;
    logic [TICK_W-1:0]      rd_tick_reg;
    logic [FLOOR_W-1:0]     rd_floor_reg;

    // Arbiter state
    logic [TICK_W-1:0] total_reg, total_next;
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [CNT_W-1:0]  last_found_reg, last_found_next;
    logic [CNT_W-1:0]  last_exec_reg, last_exec_next;
    logic [TICK_W-1:0] streak_reg, streak_next;

    // Working registers
    logic [DIV_NUM_W-1:0] prod_reg;
    logic [IDX_W-1:0]     k_reg, k_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic                 sel_valid_reg, sel_valid_next;

    // Result register
    logic              out_vld_reg, out_vld_next;
    logic [SIDX_W-1:0] out_index_reg;
    logic              out_valid_reg;
    logic [TICK_W-1:0] out_tick_reg;

    // Combinational
    logic [IDX_W-1:0]     idx_addr, rd_addr, k_succ, rot_pick, tick_waddr;
    logic                 rot_valid, tick_we;
    logic [TICK_W-1:0]    tick_wdata;
    logic [TICK_W-1:0]    mul_a, mul_b, draw;
    logic [SUM_W-1:0]     sum_add;
    logic                 hit;
    logic [DIV_NUM_W-1:0] quot;
    logic                 rem_nz, div_busy;
    logic [TICK_W-1:0]    pay, rew_tick, rew_total;
    logic [TICK_W:0]      pen_ceil, pen1;
    logic                 pen_big, keep;
    logic [TICK_W-1:0]    fl32, pen_tick, pen_total, base32, floor_total;
    logic                 raise;
    logic [IDX_W:0]       rot_ext;

    assign idx_addr = idx_reg[IDX_W-1:0];
    assign k_succ   = (k_reg == LAST_IDX) ? '0 : k_reg + 1'b1;

    // Read address select
    always_comb begin
        case (cmd.rd_sel)
            RD_IDX:  rd_addr = idx_addr;
            RD_WIN:  rd_addr = cur_reg;
            RD_WALK: rd_addr = cmd.walk_clr ? '0 : k_succ;
            RD_PICK: rd_addr = rot_pick;
            default: rd_addr = cur_reg;
        endcase
    end

    // Shared multiplier operands
    always_comb begin
        case (cmd.mul_sel)
            MUL_REWARD: begin
                mul_a = TICK_W'(NUM_SOURCES);
                mul_b = total_reg - rd_tick_reg;
            end
            MUL_PENALTY: begin
                mul_a = streak_reg;
                mul_b = rd_tick_reg;
            end
            default: begin
                mul_a = total_reg;
                mul_b = TICK_W'(rnd_reg);
            end
        endcase
    end

    fls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (prod_reg),
        .den     (total_reg),
        .busy    (div_busy),
        .quot    (quot),
        .rem_nz  (rem_nz)
    );

    // Running-sum walk against the draw
    assign draw    = prod_reg[RAND_BITS +: TICK_W];
    assign sum_add = sum_reg + SUM_W'(rd_tick_reg);
    assign hit     = sum_add > SUM_W'(draw);

    // Rotate to the next non-empty source when the drawn one is empty
    always_comb begin
        rot_pick  = pick_reg;
        rot_valid = mask_reg[pick_reg];
        rot_ext   = '0;
        if (!rot_valid) begin
            for (int i = 1; i <= NUM_SOURCES; i++) begin
                rot_ext = {1'b0, pick_reg} + (IDX_W+1)'(i);
                if (rot_ext >= (IDX_W+1)'(NUM_SOURCES)) begin
                    rot_ext = rot_ext - (IDX_W+1)'(NUM_SOURCES);
                end
                if (!rot_valid && mask_reg[rot_ext[IDX_W-1:0]]) begin
                    rot_valid = 1'b1;
                    rot_pick  = rot_ext[IDX_W-1:0];
                end
            end
        end
    end

    // Reward: ceil(N*(T-b)/T) with the zero-total and winner-above-total cases
    always_comb begin
        if (total_reg == '0) begin
            pay = TICK_W'(NUM_SOURCES);
        end else if (rd_tick_reg > total_reg) begin
            pay = '0;
        end else begin
            pay = quot[TICK_W-1:0] + TICK_W'(rem_nz);
        end
        rew_tick  = sat_add32(rd_tick_reg, pay);
        rew_total = sat_add32(total_reg, pay);
    end

    // Penalty: ceil(s*b/T)+1, never below the floor
    always_comb begin
        pen_ceil = {1'b0, quot[TICK_W-1:0]} + (TICK_W+1)'(rem_nz);
        pen_big  = (|quot[DIV_NUM_W-1:TICK_W]) || (pen_ceil >= {1'b0, TICK_MAX});
        if (total_reg == '0) begin
            pen1 = (TICK_W+1)'(1);
        end else if (pen_big) begin
            pen1 = {1'b1, {TICK_W{1'b0}}};
        end else begin
            pen1 = pen_ceil + (TICK_W+1)'(1);
        end
        fl32 = TICK_W'(rd_floor_reg);
        keep = (rd_tick_reg > fl32) && ({1'b0, rd_tick_reg - fl32} > pen1);
        pen_tick = keep ? (rd_tick_reg - pen1[TICK_W-1:0]) : fl32;
        if (pen_tick >= rd_tick_reg) begin
            pen_total = sat_add32(total_reg, pen_tick - rd_tick_reg);
        end else begin
            pen_total = clamp_sub32(total_reg, rd_tick_reg - pen_tick);
        end
    end

    // Set floor: raise tickets to the new floor
    assign base32      = TICK_W'(base_reg);
    assign raise       = base32 > rd_tick_reg;
    assign floor_total = sat_add32(total_reg, base32 - rd_tick_reg);

    // Ticket store write port
    always_comb begin
        tick_we    = 1'b0;
        tick_waddr = cur_reg;
        tick_wdata = pen_tick;
        if (cmd.floor_wr) begin
            tick_we    = raise;
            tick_waddr = idx_addr;
            tick_wdata = base32;
        end else if (cmd.adj_wr) begin
            tick_we    = 1'b1;
            tick_wdata = status.reward ? rew_tick : pen_tick;
        end
    end

    // Next state of the control-side registers
    always_comb begin
        tick_vld_next   = tick_vld_reg;
        floor_vld_next  = floor_vld_reg;
        total_next      = total_reg;
        cur_next        = cur_reg;
        last_found_next = last_found_reg;
        last_exec_next  = last_exec_reg;
        streak_next     = streak_reg;
        k_next          = k_reg;
        sum_next        = sum_reg;
        pick_next       = pick_reg;
        sel_valid_next  = sel_valid_reg;
        out_vld_next    = out_vld_reg && !m_tready;

        if (tick_we) begin
            tick_vld_next[tick_waddr] = 1'b1;
        end
        if (cmd.floor_wr) begin
            floor_vld_next[idx_addr] = 1'b1;
            if (raise) begin
                total_next = floor_total;
            end
        end
        if (cmd.streak_inc) begin
            streak_next = sat_add32(streak_reg, TICK_W'(1));
        end
        if (cmd.adj_wr) begin
            if (status.reward) begin
                total_next      = rew_total;
                last_found_next = found_reg;
                streak_next     = '0;
            end else begin
                total_next = pen_total;
            end
        end
        if (cmd.walk_clr) begin
            last_exec_next = exec_reg;
            k_next         = '0;
            sum_next       = '0;
        end
        if (cmd.walk_step) begin
            k_next    = k_succ;
            sum_next  = sum_add;
            pick_next = k_reg;
        end
        if (cmd.rotate) begin
            pick_next      = rot_pick;
            cur_next       = rot_pick;
            sel_valid_next = rot_valid;
        end
        if (cmd.load_out) begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_vld_reg   <= '0;
            floor_vld_reg  <= '0;
            total_reg      <= TICK_W'(NUM_SOURCES);
            cur_reg        <= '0;
            last_found_reg <= '0;
            last_exec_reg  <= '0;
            streak_reg     <= '0;
            out_vld_reg    <= 1'b0;
        end else begin
            tick_vld_reg   <= tick_vld_next;
            floor_vld_reg  <= floor_vld_next;
            total_reg      <= total_next;
            cur_reg        <= cur_next;
            last_found_reg <= last_found_next;
            last_exec_reg  <= last_exec_next;
            streak_reg     <= streak_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        sum_reg       <= sum_next;
        pick_reg      <= pick_next;
        sel_valid_reg <= sel_valid_next;
        if (cmd.capture) begin
            req_reg   <= s_tuser;
            idx_reg   <= s_tdata[IDX_LSB +: SIDX_W];
            base_reg  <= s_tdata[BASE_LSB +: FLOOR_W];
            found_reg <= s_tdata[FOUND_LSB +: CNT_W];
            exec_reg  <= s_tdata[EXEC_LSB +: CNT_W];
            rnd_reg   <= s_tdata[RND_LSB +: RND_W];
            mask_reg  <= s_tdata[MASK_LSB +: MASK_W];
        end
        if (cmd.mul_en) begin
            prod_reg <= DIV_NUM_W'(mul_a) * DIV_NUM_W'(mul_b);
        end
        if (cmd.load_out) begin
            out_index_reg <= sel_valid_reg ? SIDX_W'(pick_reg) : '0;
            out_valid_reg <= sel_valid_reg;
            out_tick_reg  <= sel_valid_reg ? rd_tick_reg : '0;
        end
    end

    // Store write and registered read
    always_ff @(posedge aclk) begin
        if (tick_we) begin
            tick_mem[tick_waddr] <= tick_wdata;
        end
        if (cmd.floor_wr) begin
            floor_mem[idx_addr] <= base_reg;
        end
        if (cmd.rd_en) begin
            rd_tick_reg  <= tick_vld_reg[rd_addr] ? tick_mem[rd_addr] : TICK_W'(1);
            rd_floor_reg <= floor_vld_reg[rd_addr] ? floor_mem[rd_addr] : FLOOR_W'(1);
        end
    end

    // Status to the controller
    always_comb begin
        status.req_set   = req_reg;
        status.idx_ok    = {1'b0, idx_reg} < (SIDX_W+1)'(NUM_SOURCES);
        status.reward    = found_reg > last_found_reg;
        status.penalty   = exec_reg != last_exec_reg;
        status.t_zero    = total_reg == '0;
        status.b_gt_t    = rd_tick_reg > total_reg;
        status.div_busy  = div_busy;
        status.walk_done = hit || (k_reg == LAST_IDX);
        status.out_free  = !out_vld_reg || m_tready;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_tick_reg, out_index_reg};
    assign m_tuser  = out_valid_reg;

endmodule

// ===== sv/feedback_lottery_selector.sv =====
// ============================================================================
// feedback_lottery_selector: lottery arbiter with adaptive tickets
// Usage:
//   Slave channel carries one request per transfer. s_tuser is the kind:
//   1 sets a source's floor (no result), 0 asks for a selection.
//   Master channel carries one result per selection; m_tuser flags that
//   a non-empty source was found.
// Flow:
//   One request is in flight at a time; s_tready is high only while idle.
//   Set floor: decode, then the floor write, then back to idle.
//   Select: decode, adjustment check, draw, the walk over up to NUM_SOURCES
//   sources, rotation and hand-off when the last winner is left alone; a reward
//   or penalty adds the multiply, the 64-step radix-2 divider and the ticket
//   write, or only the ticket write when the total is zero or a reward meets a winner above the total.
// Reset:
//   Every source holds one ticket and a floor of one, the total is
//   NUM_SOURCES and all history counters are zero. No clearing pass.
// Stall:
//   A result waits in the output register; the next request is still taken
//   and worked on, and only its own hand-off waits for that register.
// ============================================================================
module feedback_lottery_selector #(
    parameter int NUM_SOURCES = fls_pkg::FLS_NUM_SOURCES,
    parameter int RAND_BITS   = fls_pkg::FLS_RAND_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata, low bit up: searcher_index[3], base_value[16], found_count[48],
    // executed_count[48], random_fraction[16], nonempty_mask[8], zero fill
    input  logic [fls_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: req_type[1]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata, low bit up: chosen_index[3], chosen_tickets[32], zero fill
    output logic [fls_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: chosen_valid[1]
    output logic                          m_tuser
);
    import fls_pkg::*;

    fls_cmd_t    cmd;
    fls_status_t status;

    fls_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fls_dp #(
        .NUM_SOURCES (NUM_SOURCES),
        .RAND_BITS   (RAND_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    // A taken request drops s_tready in the next cycle
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // Never overwrite a result that has not been transferred
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> status.out_free)
        else $error("result register overwritten");

    // The divider is started only when free
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> !status.div_busy)
        else $error("divider restarted while busy");

    // An empty selection carries zero index and tickets
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("empty selection with nonzero payload");

endmodule

// ===== dv/tb_top.sv =====
// ============================================================================
// tb_top: stream-level test of the lottery selector
// A table of directed requests runs first. It covers reset picks, all-empty
// masks, floors dropped to zero, the ticket total driven to zero, the draw
// running past every sum, and maximum floors and counts. Several hundred
// random floor updates and selections follow. Each selection is checked,
// against a typed row's pick or a behavioral model of the ticket arithmetic,
// under random sender bursts, receiver stalls and one long receiver hold-off.
// ============================================================================
module tb_top;

    import fls_pkg::*;

    localparam int NSRC  = FLS_NUM_SOURCES;
    localparam int RBITS = FLS_RAND_BITS;

    // Request kind as carried on s_tuser
    typedef enum logic {
        REQ_SELECT    = 1'b0,
        REQ_SET_FLOOR = 1'b1
    } req_kind_t;

    // Receiver stall patterns
    typedef enum int {
        RX_FREE,
        RX_CHOPPY,
        RX_SLOW
    } rx_mode_t;

    typedef struct packed {
        req_kind_t   kind;
        logic [2:0]  src;
        logic [15:0] floor_val;
        logic [47:0] found;
        logic [47:0] executed;
        logic [15:0] frac;
        logic [7:0]  mask;
    } lot_req_t;

    typedef struct packed {
        logic [2:0]  src;
        logic        hit;
        logic [31:0] tickets;
    } lot_pick_t;

    typedef struct packed {
        lot_req_t  rq;
        logic      typed;
        lot_pick_t want;
    } plan_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // s_tdata, low bit up: searcher_index, base_value, found_count,
    // executed_count, random_fraction, nonempty_mask, zero fill
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // s_tuser: req_type
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // m_tdata, low bit up: chosen_index, chosen_tickets, zero fill
    logic [M_TDATA_W-1:0] m_tdata;
    // m_tuser: chosen_valid
    logic                 m_tuser;

    // Model state of the ticket scheduler
    logic [31:0] tk [NSRC];
    logic [15:0] fl [NSRC];
    logic [31:0] tk_total;
    logic [2:0]  cur_src;
    logic [47:0] seen_found;
    logic [47:0] seen_exec;
    logic [31:0] streak;

    // Random stimulus history
    logic [47:0] gen_found = 48'd2;
    logic [47:0] gen_exec  = 48'd0;

    lot_pick_t picks_due[$];
    plan_row_t plan[$];

    int errors      = 0;
    int n_select    = 0;
    int n_floor     = 0;
    int n_reward    = 0;
    int n_penalty   = 0;
    int n_results   = 0;
    int n_empty     = 0;
    int burst_left  = 0;
    bit random_live = 1'b0;

    feedback_lottery_selector i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    // Saturate a wide count to 32 bits
    function automatic logic [31:0] sat32(input longint unsigned v);
        return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    // Move the ticket total by the change of one source's tickets
    function automatic void shift_total(input longint unsigned old_v,
                                        input longint unsigned new_v);
        longint unsigned tot;
        tot = tk_total;
        if (new_v >= old_v)
            tk_total = sat32(tot + (new_v - old_v));
        else
            tk_total = (tot >= old_v - new_v) ? 32'(tot - (old_v - new_v)) : 32'd0;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(input plan_row_t row);
        plan = {plan, row};
    endfunction

    // Queue one pick that a result transfer must match
    function automatic void queue_pick(input lot_pick_t pk);
        picks_due = {picks_due, pk};
    endfunction

    // Update the ticket state for one request and work out its pick
    task automatic lottery_step(input lot_req_t rq, output bit produced,
                                output lot_pick_t res);
        longint unsigned b, t, pay, pen, nv, num, draw, run, r;
        int w, p, k;
        bit ok;
        produced = 1'b0;
        res = '0;
        if (rq.kind == REQ_SET_FLOOR) begin
            n_floor++;
            if (int'(rq.src) < NSRC) begin
                fl[rq.src] = rq.floor_val;
                if (rq.floor_val > tk[rq.src]) begin
                    shift_total(tk[rq.src], rq.floor_val);
                    tk[rq.src] = 32'(rq.floor_val);
                end
            end
            return;
        end
        n_select++;
        w = cur_src;
        b = tk[w];
        t = tk_total;
        // Reward the last winner when new instructions were found
        if (rq.found > seen_found) begin
            n_reward++;
            if (t == 0) begin
                pay = NSRC;
            end else if (b > t) begin
                pay = 0;
            end else begin
                num = NSRC * (t - b);
                pay = num / t + ((num % t) != 0);
            end
            tk[w] = sat32(b + pay);
            tk_total = sat32(longint'(tk_total) + pay);
            seen_found = rq.found;
            streak = '0;
        // Penalize it when it only executed, never below its floor
        end else if (rq.executed != seen_exec) begin
            n_penalty++;
            streak = sat32(longint'(streak) + 1);
            if (t == 0) begin
                pen = 0;
            end else begin
                num = longint'(streak) * b;
                pen = num / t + ((num % t) != 0);
            end
            pen = pen + 1;
            if (b > fl[w] && b - fl[w] > pen)
                nv = b - pen;
            else
                nv = fl[w];
            shift_total(b, nv);
            tk[w] = 32'(nv);
        end
        seen_exec = rq.executed;

        // Draw and walk the running sums; past every sum the last source wins
        r = rq.frac[RBITS-1:0];
        draw = (longint'(tk_total) * r) >> RBITS;
        p = NSRC - 1;
        run = 0;
        for (k = 0; k < NSRC; k++) begin
            run += tk[k];
            if (run > draw) begin
                p = k;
                break;
            end
        end

        // Rotate onward past empty sources
        ok = rq.mask[p];
        if (!ok) begin
            for (k = 0; k < NSRC; k++) begin
                p = (p + 1) % NSRC;
                if (rq.mask[p]) begin
                    ok = 1'b1;
                    break;
                end
            end
        end
        cur_src = 3'(p);
        produced = 1'b1;
        if (ok)
            res = '{3'(p), 1'b1, tk[p]};
    endtask

    // Offer one request, wait for the transfer, then log what it should yield
    task automatic offer(input lot_req_t rq, input logic typed, input lot_pick_t want);
        bit produced;
        lot_pick_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= rq.kind;
        s_tdata  <= S_TDATA_W'({rq.mask, rq.frac, rq.executed, rq.found,
                                rq.floor_val, rq.src});
        do @(posedge aclk); while (!s_tready);
        lottery_step(rq, produced, predicted);
        if (produced)
            queue_pick(typed ? want : predicted);
    endtask

    // Pace the sender in bursts separated by gaps of varied length
    task automatic pace();
        int gap, roll;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        roll = $urandom_range(0, 99);
        if (roll < 50)
            gap = $urandom_range(0, 3);
        else if (roll < 85)
            gap = $urandom_range(4, 20);
        else
            gap = $urandom_range(30, 90);
        burst_left = (roll < 20) ? $urandom_range(20, 40) : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Build a random request, mostly well-formed select streams
    task automatic random_request(output lot_req_t rq);
        int roll;
        rq.kind      = REQ_SELECT;
        rq.src       = 3'($urandom);
        rq.floor_val = 16'($urandom);
        rq.frac      = 16'($urandom);
        rq.mask      = 8'($urandom);
        rq.found     = {16'($urandom), 32'($urandom)};
        rq.executed  = {16'($urandom), 32'($urandom)};
        if ($urandom_range(0, 99) < 18) begin
            rq.kind = REQ_SET_FLOOR;
            roll = $urandom_range(0, 99);
            if (roll < 60)
                rq.floor_val = 16'($urandom_range(0, 40));
            else if (roll < 85)
                rq.floor_val = 16'($urandom_range(0, 2000));
            return;
        end

        // Found count climbs, with rare big jumps and one-off lower values
        roll = $urandom_range(0, 99);
        if (roll < 4 && gen_found < 48'h8000_0000_0000)
            gen_found = gen_found + {14'($urandom), 32'($urandom)};
        else if (roll < 34)
            gen_found = gen_found + 48'($urandom_range(1, 1000));
        if (roll >= 90)
            rq.found = gen_found & rq.found;
        else
            rq.found = gen_found;

        // Executed count mostly advances, sometimes jumps anywhere
        roll = $urandom_range(0, 99);
        if (roll < 55)
            gen_exec = gen_exec + 48'($urandom_range(1, 5000));
        else if (roll < 60)
            gen_exec = rq.executed;
        rq.executed = gen_exec;

        roll = $urandom_range(0, 99);
        if (roll < 10)
            rq.mask = 8'h00;
        else if (roll < 20)
            rq.mask = 8'(1 << $urandom_range(0, NSRC - 1));
        else if (roll < 30)
            rq.mask = 8'hFF;
    endtask

    // Stimulus: reset, directed table, random stream, closing extreme
    initial begin
        lot_req_t rq;
        lot_pick_t none;
        int k;
        none = '0;
        for (k = 0; k < NSRC; k++) begin
            tk[k] = 32'd1;
            fl[k] = 16'd1;
        end
        tk_total   = 32'(NSRC);
        cur_src    = '0;
        seen_found = '0;
        seen_exec  = '0;
        streak     = '0;

        // Picks straight after reset, all-empty and rotate to the top source
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd0, 48'd0, 16'h0000, 8'hFF},
                  1'b1, '{3'd0, 1'b1, 32'd1}});
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd0, 48'd0, 16'hFFFF, 8'hFF},
                  1'b1, '{3'd7, 1'b1, 32'd1}});
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd0, 48'd0, 16'h0000, 8'h00},
                  1'b1, '{3'd0, 1'b0, 32'd0}});
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd0, 48'd0, 16'h0000, 8'h80},
                  1'b1, '{3'd7, 1'b1, 32'd1}});
        // Drop every floor to zero
        for (k = 0; k < NSRC; k++)
            add_row('{'{REQ_SET_FLOOR, 3'(k), 16'd0, 48'd0, 48'd0, 16'd0, 8'h00},
                      1'b0, none});
        // Penalize each source in turn until the ticket total is zero
        for (k = 1; k <= NSRC; k++)
            add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd0, 48'(k), 16'h0000,
                        (k < NSRC) ? 8'(1 << (k - 1)) : 8'h00},
                      (k == NSRC), none});
        // Penalty and reward with a zero total; the draw runs past every sum
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd0, 48'd9, 16'h0000, 8'hFF},
                  1'b1, '{3'd7, 1'b1, 32'd0}});
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd1, 48'd9, 16'hFFFF, 8'hFF},
                  1'b1, '{3'd7, 1'b1, 32'd8}});
        // Largest floor, then reward and penalty at extreme counts
        add_row('{'{REQ_SET_FLOOR, 3'd3, 16'hFFFF, 48'd0, 48'd0, 16'd0, 8'h00},
                  1'b0, none});
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd2, '1, 16'h8000, 8'hAA},
                  1'b0, none});
        add_row('{'{REQ_SELECT, 3'd0, 16'd0, 48'd2, 48'd0, 16'h1234, 8'h55},
                  1'b0, none});

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            offer(plan[i].rq, plan[i].typed, plan[i].want);
            pace();
        end

        random_live = 1'b1;
        repeat (575) begin
            random_request(rq);
            offer(rq, 1'b0, none);
            pace();
        end

        // Close with both counts at their maximum
        rq = '{REQ_SELECT, 3'd0, 16'd0, '1, '1, 16'($urandom), 8'hFF};
        offer(rq, 1'b0, none);
        s_tvalid <= 1'b0;

        while (picks_due.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("Covered %0d selections (%0d rewards, %0d penalties) and %0d floor updates.",
                 n_select, n_reward, n_penalty, n_floor);
        $display("Checked %0d results, %0d of them with every source empty; %0d errors.",
                 n_results, n_empty, errors);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Receiver: change stall pattern now and then, hold off once for long
    initial begin
        rx_mode_t mode;
        int len;
        bit held;
        held = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            mode = rx_mode_t'($urandom_range(0, 2));
            len = $urandom_range(20, 300);
            repeat (len) begin
                @(posedge aclk);
                case (mode)
                    RX_FREE:   m_tready <= 1'b1;
                    RX_CHOPPY: m_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_tready <= ($urandom_range(0, 4) == 0);
                endcase
            end
            if (random_live && !held) begin
                held = 1'b1;
                @(posedge aclk);
                m_tready <= 1'b0;
                repeat (600) @(posedge aclk);
            end
        end
    end

    // Compare each result transfer with the oldest pending pick
    always @(posedge aclk) begin
        lot_pick_t want;
        lot_pick_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[2:0], m_tuser, m_tdata[34:3]};
            n_results++;
            if (!got.hit)
                n_empty++;
            if (picks_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result index %0d valid %0d tickets %0d",
                         $time, got.src, got.hit, got.tickets);
            end else begin
                want = picks_due.pop_front();
                if (got.src !== want.src) begin
                    errors++;
                    $display("%0t: chosen_index expected %0d got %0d",
                             $time, want.src, got.src);
                end
                if (got.hit !== want.hit) begin
                    errors++;
                    $display("%0t: chosen_valid expected %0d got %0d",
                             $time, want.hit, got.hit);
                end
                if (got.tickets !== want.tickets) begin
                    errors++;
                    $display("%0t: chosen_tickets expected %0d got %0d",
                             $time, want.tickets, got.tickets);
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        #4_000_000;
        $display("Timeout with %0d results still pending.", picks_due.size());
        $display("simulation failed");
        $finish;
    end

endmodule
